// ----- rtl/core/bdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// bdlp_pkg
// types, codes and constants shared by the button debouncer with
// long-press repeat
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

    // number of buttons kept in the state memory
    localparam int BUTTONS = 8;
    localparam int ADDR_W  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

    localparam int BTN_W  = 3;
    localparam int TIME_W = 32;
    localparam int HIST_W = 16;
    localparam int MS_W   = 16;
    localparam int EV_W   = 2;

    // event codes
    localparam logic [EV_W-1:0] EV_DOWN = 2'd0;
    localparam logic [EV_W-1:0] EV_UP   = 2'd1;
    localparam logic [EV_W-1:0] EV_HELD = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 2'd2;

    // configuration reset values
    localparam logic            RST_ACTIVE_LOW = 1'b1;
    localparam logic [MS_W-1:0] RST_LONG_PRESS = 16'd2000;
    localparam logic [MS_W-1:0] RST_REPEAT     = 16'd50;

    // edge patterns on the sample history
    localparam logic [HIST_W-1:0] EDGE_MASK  = 16'b1111000000111111;
    localparam logic [HIST_W-1:0] RISE_PAT   = 16'b0000000000111111;
    localparam logic [HIST_W-1:0] FALL_PAT   = 16'b1111000000000000;
    localparam logic [HIST_W-1:0] HIST_ONES  = 16'hffff;
    localparam logic [HIST_W-1:0] HIST_ZEROS = 16'h0000;

    typedef struct packed {
        logic [BTN_W-1:0]  button;
        logic              level;
        logic [TIME_W-1:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [BTN_W-1:0] button_out;
        logic [EV_W-1:0]  event_res;
    } t_out;

    // one entry of the per-button state memory
    typedef struct packed {
        logic [HIST_W-1:0] history;
        logic              pressed;
        logic [TIME_W-1:0] hold_deadline;
    } t_state;

    typedef struct packed {
        logic            active_low;
        logic [MS_W-1:0] long_press_ms;
        logic [MS_W-1:0] repeat_ms;
    } t_cfg;

    typedef struct packed {
        logic            vld;
        logic [EV_W-1:0] kind;
    } t_evt;

    // state of a button that was never written
    localparam t_state RST_STATE = '{history: HIST_ONES, pressed: 1'b0,
                                     hold_deadline: '0};

endpackage

`default_nettype wire

// ----- rtl/core/bdlp_update.sv -----
// ----------------------------------------------------------------------------
// bdlp_update
// per-button read-modify-write step: shift, edge match, held deadline
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_update (
    input  var bdlp_pkg::t_state           i_cur,
    input  var logic                       i_level,
    input  var logic [bdlp_pkg::TIME_W-1:0] i_now_ms,
    input  var bdlp_pkg::t_cfg             i_cfg,
    output bdlp_pkg::t_state               o_nxt,
    output bdlp_pkg::t_evt                 o_evt
);

    logic [bdlp_pkg::HIST_W-1:0] hist_sh;
    logic rise;
    logic fall;
    logic press;
    logic release_hit;
    logic held;
    logic [bdlp_pkg::HIST_W-1:0] snap;

    assign hist_sh     = {i_cur.history[bdlp_pkg::HIST_W-2:0], i_level};
    assign rise        = (hist_sh & bdlp_pkg::EDGE_MASK) == bdlp_pkg::RISE_PAT;
    assign fall        = (hist_sh & bdlp_pkg::EDGE_MASK) == bdlp_pkg::FALL_PAT;
    assign press       = i_cfg.active_low ? fall : rise;
    assign release_hit = i_cfg.active_low ? rise : fall;
    assign held        = i_cur.pressed && (i_now_ms >= i_cur.hold_deadline);
    // rise snaps to all ones, fall to all zeros
    assign snap        = rise ? bdlp_pkg::HIST_ONES : bdlp_pkg::HIST_ZEROS;

    always_comb begin
        o_nxt         = i_cur;
        o_nxt.history = hist_sh;
        o_evt.vld     = 1'b0;
        o_evt.kind    = bdlp_pkg::EV_DOWN;
        if (held) begin
            // held wins, history is not snapped
            o_nxt.hold_deadline = i_cur.hold_deadline
                                + bdlp_pkg::TIME_W'(i_cfg.repeat_ms);
            o_evt.vld  = 1'b1;
            o_evt.kind = bdlp_pkg::EV_HELD;
        end else if (press) begin
            // snapped history never matches the release pattern
            o_nxt.history = snap;
            if (!i_cur.pressed) begin
                o_nxt.pressed       = 1'b1;
                o_nxt.hold_deadline = i_now_ms
                                    + bdlp_pkg::TIME_W'(i_cfg.long_press_ms);
                o_evt.vld  = 1'b1;
                o_evt.kind = bdlp_pkg::EV_DOWN;
            end
        end else if (release_hit) begin
            o_nxt.history = snap;
            o_nxt.pressed = 1'b0;
            o_evt.vld     = 1'b1;
            o_evt.kind    = bdlp_pkg::EV_UP;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/button_debounce_long_press.sv -----
// ----------------------------------------------------------------------------
// button_debounce_long_press
// shift-register button debouncer with down, up and repeated held events,
// per-button state kept in a synchronous memory
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------
//  input     in         i_valid / o_ready      i_data  (button, level, now_ms)
//  output    out        o_valid / i_ready      o_data  (button_out, event_res)
//  config    in         i_cfg_we (no wait)     i_cfg_idx, i_cfg_data
//
//  one request per cycle sustained while the output is not stalled; a request
//  whose sample makes an event shows it on o_valid through the output register
//  the rate is set by the state memory: read at accept, modify and write
//  back in the update stage, with the last write forwarded for the same button
//  reset clears the valid bits of the state memory, the pipeline and the
//  output register, and loads the configuration defaults
//  a stalled output holds the stage behind it; one more request is still
//  taken while a finished event waits
//
`default_nettype none

module button_debounce_long_press (
    input  var logic                          i_clk,
    input  var logic                          i_rst_n,
    input  var logic                          i_valid,
    output logic                              o_ready,
    input  var bdlp_pkg::t_in                 i_data,
    output logic                              o_valid,
    input  var logic                          i_ready,
    output bdlp_pkg::t_out                    o_data,
    input  var logic                          i_cfg_we,
    input  var logic [bdlp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  var logic [bdlp_pkg::MS_W-1:0]     i_cfg_data
);

    // configuration registers
    bdlp_pkg::t_cfg r_cfg;

    // state memory and its valid bits
    bdlp_pkg::t_state              mem [bdlp_pkg::BUTTONS];
    bdlp_pkg::t_state              r_rd_data;
    logic [bdlp_pkg::BUTTONS-1:0]  r_vld;

    // update stage
    logic                          r_s1_vld;
    logic                          r_s1_inr;
    logic                          r_s1_fwd;
    logic [bdlp_pkg::ADDR_W-1:0]   r_s1_addr;
    logic [bdlp_pkg::BTN_W-1:0]    r_s1_button;
    logic                          r_s1_level;
    logic [bdlp_pkg::TIME_W-1:0]   r_s1_now;
    bdlp_pkg::t_state              r_fwd_data;

    // output register
    logic                          r_out_vld;
    bdlp_pkg::t_out                r_out;

    logic                          in_acc;
    logic                          s1_go;
    logic                          s1_fire;
    logic                          s1_wr;
    logic                          in_range;
    logic [bdlp_pkg::ADDR_W-1:0]   rd_addr;
    bdlp_pkg::t_state              cur;
    bdlp_pkg::t_state              upd;
    bdlp_pkg::t_evt                evt;
    logic                          n_out_vld;

    // handshake and stage control
    assign s1_go    = !r_out_vld || i_ready;
    assign s1_fire  = r_s1_vld && s1_go;
    assign s1_wr    = s1_fire && r_s1_inr;
    assign o_ready  = !r_s1_vld || s1_go;
    assign in_acc   = i_valid && o_ready;
    assign rd_addr  = bdlp_pkg::ADDR_W'(i_data.button);
    // indexes past the last button are dropped without touching state
    assign in_range = 32'(i_data.button) < bdlp_pkg::BUTTONS;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low    <= bdlp_pkg::RST_ACTIVE_LOW;
            r_cfg.long_press_ms <= bdlp_pkg::RST_LONG_PRESS;
            r_cfg.repeat_ms     <= bdlp_pkg::RST_REPEAT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bdlp_pkg::CFG_ACTIVE_LOW: r_cfg.active_low    <= i_cfg_data[0];
                bdlp_pkg::CFG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_data;
                bdlp_pkg::CFG_REPEAT:     r_cfg.repeat_ms     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state memory: write-back from the update stage, read at accept
    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            mem[r_s1_addr] <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // an entry never written reads as the reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s1_wr) begin
            r_vld[r_s1_addr] <= 1'b1;
        end
    end

    // update stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s1_fwd <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
            // the write at this edge is missed by the read of the same entry
            r_s1_fwd <= s1_wr && (r_s1_addr == rd_addr);
        end else if (s1_fire) begin
            r_s1_vld <= 1'b0;
            r_s1_fwd <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_inr    <= in_range;
            r_s1_addr   <= rd_addr;
            r_s1_button <= i_data.button;
            r_s1_level  <= i_data.level;
            r_s1_now    <= i_data.now_ms;
        end
        if (s1_wr) begin
            r_fwd_data <= upd;
        end
    end

    // pick the freshest copy of this button's state
    always_comb begin
        if (r_s1_fwd) begin
            cur = r_fwd_data;
        end else if (r_vld[r_s1_addr]) begin
            cur = r_rd_data;
        end else begin
            cur = bdlp_pkg::RST_STATE;
        end
    end

    bdlp_update u_update (
        .i_cur    (cur),
        .i_level  (r_s1_level),
        .i_now_ms (r_s1_now),
        .i_cfg    (r_cfg),
        .o_nxt    (upd),
        .o_evt    (evt)
    );

    // output register
    always_comb begin
        n_out_vld = r_out_vld && !i_ready;
        if (s1_fire && r_s1_inr && evt.vld) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_inr && evt.vld) begin
            r_out.button_out <= r_s1_button;
            r_out.event_res  <= evt.kind;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // a stalled request in the update stage is neither lost nor moved
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_go |=> r_s1_vld && $stable(r_s1_addr) && $stable(r_s1_now))
        else $error("update stage lost a stalled request");

    // a written entry is valid from then on
    a_vld_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_wr |=> r_vld[$past(r_s1_addr)])
        else $error("written state entry not marked valid");

    // down always leaves the button pressed, up always released
    a_down_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && evt.vld && (evt.kind == bdlp_pkg::EV_DOWN || evt.kind == bdlp_pkg::EV_UP)
        |-> upd.pressed == (evt.kind == bdlp_pkg::EV_DOWN))
        else $error("pressed flag disagrees with event");

    // held only fires on a pressed button
    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && evt.vld && evt.kind == bdlp_pkg::EV_HELD |-> cur.pressed && upd.pressed)
        else $error("held event on a released button");

endmodule

`default_nettype wire
